/* rtl/nscl_pkg.sv */
// shared types and constants of the nearest seed color lookup
package nscl_pkg;

    localparam int MAX_SEEDS  = 256;
    localparam int COORD_BITS = 16;

    // coordinates are taken within the 16-bit field and modulo 2^COORD_BITS
    localparam int FIELD_W = 16;
    localparam int CW      = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SQ_W    = 2 * CW;
    localparam int DIST_W  = SQ_W + 1;
    localparam int IDX_W   = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEEDS + 1);

    typedef logic [CW-1:0]     coord_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [23:0]       color_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } op_e;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  seed_red;
        logic [7:0]  seed_green;
        logic [7:0]  seed_blue;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  nearest_index;
        logic [32:0] nearest_distance_sq;
        logic        overflow;
    } rsp_t;

    // token that walks down the cell chain: a load or a query
    typedef struct packed {
        logic   vld;
        logic   is_query;
        idx_t   slot;
        cnt_t   cnt;
        coord_t px;
        coord_t py;
        color_t color;
        logic   ovf;
        logic   have;
        dist_t  best_d;
        idx_t   best_i;
        color_t best_c;
    } tok_t;

endpackage

/* rtl/nscl_head.sv */
// input stage: seed count, overflow flag and token launch
module nscl_head import nscl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic req_valid,
    input  req_t req,
    output tok_t tok
);

    cnt_t count_reg, count_next;
    logic ovf_reg, ovf_next;
    logic tok_vld_reg, tok_vld_next;
    tok_t tok_reg, tok_next;
    logic acc;

    assign acc = req_valid && adv;

    always_comb
    begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        tok_vld_next = 1'b0;
        tok_next          = '0;
        tok_next.px       = req.pos_x[CW-1:0];
        tok_next.py       = req.pos_y[CW-1:0];
        tok_next.color    = {req.seed_red, req.seed_green, req.seed_blue};
        tok_next.slot     = idx_t'(count_reg);
        tok_next.cnt      = count_reg;
        tok_next.ovf      = ovf_reg;
        if (acc)
        begin
            case (req.op)
                OP_CLEAR:
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                OP_LOAD:
                begin
                    if (count_reg < cnt_t'(MAX_SEEDS))
                    begin
                        tok_vld_next = 1'b1;
                        count_next   = count_reg + cnt_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                OP_QUERY:
                begin
                    tok_vld_next      = 1'b1;
                    tok_next.is_query = 1'b1;
                end
                default:
                begin
                    tok_vld_next = 1'b0;
                end
            endcase
        end
        tok_next.vld = tok_vld_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (adv)
            begin
                tok_vld_reg <= tok_vld_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_comb
    begin
        tok     = tok_reg;
        tok.vld = tok_vld_reg;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_SEEDS))
        else $error("seed count beyond table size");

    a_full_load_sets_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req.op == OP_LOAD && count_reg == cnt_t'(MAX_SEEDS)) |=> ovf_reg)
        else $error("dropped load did not set overflow");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req.op == OP_CLEAR) |=> (count_reg == '0 && !ovf_reg))
        else $error("clear did not empty the table");
`endif

endmodule

/* rtl/nscl_cell.sv */
// one seed cell: holds a seed, squares the distances, keeps the running best
module nscl_cell import nscl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  idx_t cell_index,
    input  tok_t tok_in,
    output tok_t tok_out
);

    coord_t seed_x_reg, seed_y_reg;
    color_t seed_c_reg;

    // first stage: squares of the differences
    logic   a_vld_reg;
    tok_t   a_tok_reg;
    sq_t    a_sqx_reg, a_sqy_reg, a_sqx_next, a_sqy_next;
    color_t a_col_reg;
    logic   a_hit_reg, a_hit_next;
    coord_t dx, dy;

    // second stage: sum, compare, update
    logic   b_vld_reg;
    tok_t   b_tok_reg, b_tok_next;
    dist_t  d;

    always_comb
    begin
        dx = (tok_in.px >= seed_x_reg) ? (tok_in.px - seed_x_reg)
                                        : (seed_x_reg - tok_in.px);
        dy = (tok_in.py >= seed_y_reg) ? (tok_in.py - seed_y_reg)
                                        : (seed_y_reg - tok_in.py);
        a_sqx_next = sq_t'(dx) * sq_t'(dx);
        a_sqy_next = sq_t'(dy) * sq_t'(dy);
        a_hit_next = tok_in.vld && tok_in.is_query && (cnt_t'(cell_index) < tok_in.cnt);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (tok_in.vld && !tok_in.is_query && tok_in.slot == cell_index)
            begin
                seed_x_reg <= tok_in.px;
                seed_y_reg <= tok_in.py;
                seed_c_reg <= tok_in.color;
            end
            a_tok_reg <= tok_in;
            a_sqx_reg <= a_sqx_next;
            a_sqy_reg <= a_sqy_next;
            a_col_reg <= seed_c_reg;
            a_hit_reg <= a_hit_next;
            b_tok_reg <= b_tok_next;
        end
    end

    always_comb
    begin
        d          = dist_t'(a_sqx_reg) + dist_t'(a_sqy_reg);
        b_tok_next = a_tok_reg;
        // strict less keeps the earliest loaded seed on a tie
        if (a_hit_reg && (!a_tok_reg.have || d < a_tok_reg.best_d))
        begin
            b_tok_next.have   = 1'b1;
            b_tok_next.best_d = d;
            b_tok_next.best_i = cell_index;
            b_tok_next.best_c = a_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= tok_in.vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_comb
    begin
        tok_out     = b_tok_reg;
        tok_out.vld = b_vld_reg;
    end

endmodule

/* rtl/nearest_seed_color_lookup.sv */
// top level of the nearest seed color lookup: head, seed cell chain, result register
//
// Voronoi color lookup over a table of up to MAX_SEEDS seeds. Each request item
// is a clear (empties the table and the overflow flag), a load (appends a seed
// with its position and RGB color; on a full table the seed is dropped and the
// sticky overflow flag is set) or a query (returns the color, slot and exact
// squared Euclidean distance of the nearest seed, the earliest loaded one on a
// tie; found is 0 and all other fields are 0 on an empty table). Op code three
// is ignored. Only queries produce a response item. Every seed lives in its own
// cell of a chain; loads and queries walk the chain in order, so a query sees
// exactly the seeds loaded before it. One request item is taken every cycle as
// long as the response side keeps up; a query's response passes the head
// register, the two stages of every cell of the chain and the result register.
// While a response is held by rsp_stall the whole chain and the request side
// stall with it.
module nearest_seed_color_lookup import nscl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic adv;
    tok_t chain [0:MAX_SEEDS];
    tok_t last;
    logic rsp_valid_reg;
    rsp_t rsp_reg, rsp_next;

    // chain moves unless a finished response is waiting
    assign adv       = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !adv;

    nscl_head u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (req_valid),
        .req       (req),
        .tok       (chain[0])
    );

    for (genvar g = 0; g < MAX_SEEDS; g++)
    begin : g_cell
        nscl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .cell_index (idx_t'(g)),
            .tok_in     (chain[g]),
            .tok_out    (chain[g+1])
        );
    end

    assign last = chain[MAX_SEEDS];

    // response fields from the query leaving the chain
    always_comb
    begin
        rsp_next.found               = last.have;
        rsp_next.out_red             = last.best_c[23:16];
        rsp_next.out_green           = last.best_c[15:8];
        rsp_next.out_blue            = last.best_c[7:0];
        rsp_next.nearest_index       = 8'(last.best_i);
        rsp_next.nearest_distance_sq = 33'(last.best_d);
        rsp_next.overflow            = last.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= last.vld && last.is_query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |->
            (rsp.nearest_distance_sq == '0 && rsp.nearest_index == '0 &&
             rsp.out_red == '0 && rsp.out_green == '0 && rsp.out_blue == '0))
        else $error("empty-table response carries nonzero fields");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> req_stall)
        else $error("request taken while response is held");
`endif

endmodule

/* tb/nearest_seed_color_lookup_tb.sv */
// self-checking testbench of the nearest seed color lookup with a built-in nearest seed predictor
module nearest_seed_color_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nscl_pkg::*;

    // op code three has no meaning; the block must drop such an item
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // response delay allowance of the block, used to size the watchdog and the final drain
    localparam int PIPE_LAT       = 2 * MAX_SEEDS + 1;
    localparam int LONG_IDLE_MAX  = 60;
    // no handshake for this long means the block hung; several times the slowest correct gap
    localparam int WATCHDOG_LIMIT = 8 * (PIPE_LAT + 2 * LONG_IDLE_MAX);
    localparam int ITEM_TARGET    = 1650;
    localparam int PRINT_CAP      = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_item = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_item;

    // predictor state: our own copy of the seed table
    coord_t      seed_x[MAX_SEEDS];
    coord_t      seed_y[MAX_SEEDS];
    color_t      seed_rgb[MAX_SEEDS];
    int          seed_total = 0;
    logic        table_overflow = 1'b0;

    // responses that accepted queries are owed, oldest first
    rsp_t        expected_lookups[$];

    // when set, neither side idles, so the chain runs back to back
    bit          quiet_mode = 1'b0;

    int          items_sent = 0;
    int          loads_sent = 0;
    int          queries_sent = 0;
    int          clears_sent = 0;
    int          unused_sent = 0;
    int          loads_dropped = 0;
    int          lookups_checked = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;

    nearest_seed_color_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_item)
    );

    always #5 clk = ~clk;

    // idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_mode || roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, LONG_IDLE_MAX);
    endfunction

    // nearest seed by exact squared distance, earliest slot wins a tie
    function automatic rsp_t nearest_seed_of(coord_t qx, coord_t qy);
        rsp_t        r;
        longint      dx;
        longint      dy;
        longint      dist_sq;
        longint      best;
        int          best_slot;
        bit          have;
        r = '0;
        best = 0;
        best_slot = 0;
        have = 1'b0;
        for (int i = 0; i < seed_total; i++)
        begin
            dx = (qx >= seed_x[i]) ? (qx - seed_x[i]) : (seed_x[i] - qx);
            dy = (qy >= seed_y[i]) ? (qy - seed_y[i]) : (seed_y[i] - qy);
            dist_sq = dx * dx + dy * dy;
            if (!have || dist_sq < best)
            begin
                have = 1'b1;
                best = dist_sq;
                best_slot = i;
            end
        end
        r.found = have;
        if (have)
        begin
            r.out_red = seed_rgb[best_slot][23:16];
            r.out_green = seed_rgb[best_slot][15:8];
            r.out_blue = seed_rgb[best_slot][7:0];
        end
        r.nearest_index = best_slot[7:0];
        r.nearest_distance_sq = best[32:0];
        r.overflow = table_overflow;
        return r;
    endfunction

    // update the table copy for an item the block has taken
    task automatic track_accepted(input req_t item);
        case (item.op)
            OP_CLEAR:
            begin
                seed_total = 0;
                table_overflow = 1'b0;
                clears_sent++;
            end
            OP_LOAD:
            begin
                if (seed_total < MAX_SEEDS)
                begin
                    seed_x[seed_total] = coord_t'(item.pos_x);
                    seed_y[seed_total] = coord_t'(item.pos_y);
                    seed_rgb[seed_total] = {item.seed_red, item.seed_green, item.seed_blue};
                    seed_total++;
                end
                else
                begin
                    table_overflow = 1'b1;
                    loads_dropped++;
                end
                loads_sent++;
            end
            OP_QUERY:
            begin
                expected_lookups.push_back(
                    nearest_seed_of(coord_t'(item.pos_x), coord_t'(item.pos_y)));
                queries_sent++;
            end
            default:
                unused_sent++;
        endcase
        if (item.op != OP_UNUSED)
            items_sent++;
    endtask

    // drive one item after a random gap and hold it until taken
    task automatic send_item(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                             input logic [23:0] rgb);
        req_t item;
        int   gap;
        item.op = op;
        item.pos_x = x;
        item.pos_y = y;
        item.seed_red = rgb[23:16];
        item.seed_green = rgb[15:8];
        item.seed_blue = rgb[7:0];
        gap = pick_idle();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_item <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        track_accepted(item);
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // response side stall: random holds, none in quiet stretches
    initial
    begin : rsp_stall_driver
        int hold;
        forever
        begin
            hold = pick_idle();
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // every taken response against the oldest owed one, field by field
    always @(posedge clk)
    begin : response_checker
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (expected_lookups.size() == 0)
                report_mismatch("unrequested response", 1, 0);
            else
            begin
                want = expected_lookups.pop_front();
                lookups_checked++;
                if (rsp_item.found !== want.found)
                    report_mismatch("found", rsp_item.found, want.found);
                if (rsp_item.out_red !== want.out_red)
                    report_mismatch("out_red", rsp_item.out_red, want.out_red);
                if (rsp_item.out_green !== want.out_green)
                    report_mismatch("out_green", rsp_item.out_green, want.out_green);
                if (rsp_item.out_blue !== want.out_blue)
                    report_mismatch("out_blue", rsp_item.out_blue, want.out_blue);
                if (rsp_item.nearest_index !== want.nearest_index)
                    report_mismatch("nearest_index", rsp_item.nearest_index,
                                    want.nearest_index);
                if (rsp_item.nearest_distance_sq !== want.nearest_distance_sq)
                    report_mismatch("nearest_distance_sq", rsp_item.nearest_distance_sq,
                                    want.nearest_distance_sq);
                if (rsp_item.overflow !== want.overflow)
                    report_mismatch("overflow", rsp_item.overflow, want.overflow);
            end
        end
    end

    // hang detection: count cycles with no handshake on either side
    always @(posedge clk)
    begin : watchdog
        if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no handshake for %0d cycles, %0d responses still owed",
                     $realtime, idle_cycles, expected_lookups.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // empty table: found low, every other field zero, overflow clear
    task automatic test_empty_table();
        send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        send_item(OP_QUERY, 16'h0000, 16'h0000, 24'h000000);
        send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        send_item(OP_UNUSED, 16'hFFFF, 16'h0000, 24'hFFFFFF);
        send_item(OP_QUERY, 16'h8000, 16'h7FFF, 24'h5A5A5A);
    endtask

    // corner seeds: zero distance, largest distance, ties, duplicate position
    task automatic test_coordinate_extremes();
        send_item(OP_CLEAR, 16'h0000, 16'h0000, 24'h000000);
        send_item(OP_LOAD, 16'h0000, 16'h0000, 24'hFF00FF);
        send_item(OP_LOAD, 16'hFFFF, 16'hFFFF, 24'h00FF00);
        send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 24'h000000);
        send_item(OP_QUERY, 16'h0000, 16'h0000, 24'hFFFFFF);
        // equal distance to both corners: the earlier seed must win
        send_item(OP_QUERY, 16'hFFFF, 16'h0000, 24'h000000);
        send_item(OP_QUERY, 16'h0000, 16'hFFFF, 24'h000000);
        send_item(OP_QUERY, 16'h8000, 16'h8000, 24'h000000);
        // same spot as the first seed, must lose the tie
        send_item(OP_LOAD, 16'h0000, 16'h0000, 24'hFFFFFF);
        send_item(OP_QUERY, 16'h0000, 16'h0000, 24'h000000);
        // ignored op between two queries changes nothing
        send_item(OP_UNUSED, 16'h0000, 16'h0000, 24'h000000);
        send_item(OP_QUERY, 16'h0001, 16'h0000, 24'h000000);
        // lone far seed gives the largest squared distance
        send_item(OP_CLEAR, 16'h0000, 16'h0000, 24'h000000);
        send_item(OP_LOAD, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        send_item(OP_QUERY, 16'h0000, 16'h0000, 24'h000000);
        send_item(OP_QUERY, 16'h0000, 16'hFFFF, 24'h000000);
    endtask

    // fill every slot, overrun it, then check that clear drops the sticky flag
    task automatic test_table_full();
        int          step;
        logic [15:0] x;
        logic [15:0] y;
        step = 65536 / MAX_SEEDS;
        send_item(OP_CLEAR, 16'h0000, 16'h0000, 24'h000000);
        for (int i = 0; i < MAX_SEEDS; i++)
        begin
            // distinct x per slot so the last slot can be hit exactly
            x = 16'(i * step + $urandom_range(0, step - 1));
            y = 16'($urandom);
            send_item(OP_LOAD, x, y, 24'($urandom));
            if (i % 32 == 31)
                send_item(OP_QUERY, 16'($urandom), 16'($urandom), 24'h000000);
        end
        send_item(OP_QUERY, x, y, 24'h000000);
        repeat (3) send_item(OP_LOAD, 16'($urandom), 16'($urandom), 24'($urandom));
        send_item(OP_QUERY, x, y, 24'h000000);
        send_item(OP_QUERY, 16'h0000, 16'h0000, 24'h000000);
        send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 24'($urandom));
        send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 24'h000000);
        send_item(OP_CLEAR, 16'h0000, 16'h0000, 24'h000000);
        send_item(OP_QUERY, x, y, 24'h000000);
        send_item(OP_LOAD, x, y, 24'h123456);
        send_item(OP_QUERY, x, y, 24'h000000);
    endtask

    // clear most of the time, load a batch and query it, with stray unused ops mixed in
    task automatic test_random_sequences();
        int          loads_left;
        int          queries_left;
        int          roll;
        int          span;
        int          slot;
        logic [15:0] base_x;
        logic [15:0] base_y;
        logic [15:0] x;
        logic [15:0] y;
        while (items_sent < ITEM_TARGET)
        begin
            quiet_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) != 0)
                send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 24'($urandom));
            roll = $urandom_range(0, 99);
            if (roll < 85)
                loads_left = $urandom_range(1, 12);
            else if (roll < 97)
                loads_left = $urandom_range(13, 64);
            else
                loads_left = $urandom_range(MAX_SEEDS - 4, MAX_SEEDS + 4);
            queries_left = $urandom_range(1, 16);
            // half the batches crowd their seeds into a small window
            span = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 300);
            base_x = 16'($urandom);
            base_y = 16'($urandom);
            while (loads_left > 0 || queries_left > 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 24'($urandom));
                else if (loads_left > 0 && (queries_left == 0 || roll < 60))
                begin
                    if (seed_total > 0 && $urandom_range(0, 6) == 0)
                    begin
                        // repeat a position already in the table
                        slot = $urandom_range(0, seed_total - 1);
                        x = seed_x[slot];
                        y = seed_y[slot];
                    end
                    else
                    begin
                        x = 16'(base_x + $urandom_range(0, span));
                        y = 16'(base_y + $urandom_range(0, span));
                    end
                    send_item(OP_LOAD, x, y, 24'($urandom));
                    loads_left--;
                end
                else
                begin
                    if (seed_total > 0 && roll < 40)
                    begin
                        // on or right next to a known seed
                        slot = $urandom_range(0, seed_total - 1);
                        x = 16'(seed_x[slot] + $urandom_range(0, 6) - 3);
                        y = 16'(seed_y[slot] + $urandom_range(0, 6) - 3);
                    end
                    else if (roll < 70)
                    begin
                        x = 16'(base_x + $urandom_range(0, span));
                        y = 16'(base_y + $urandom_range(0, span));
                    end
                    else
                    begin
                        x = 16'($urandom);
                        y = 16'($urandom);
                    end
                    send_item(OP_QUERY, x, y, 24'($urandom));
                    queries_left--;
                end
            end
        end
        quiet_mode = 1'b0;
    endtask

    initial
    begin : run_tests
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_coordinate_extremes();
        test_table_full();
        test_random_sequences();

        req_valid <= 1'b0;
        // drain the chain, then give stray responses time to show up
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 16) @(posedge clk);

        $display("covered %0d items: %0d clears, %0d loads (%0d dropped on a full table),",
                 items_sent, clears_sent, loads_sent, loads_dropped);
        $display("%0d queries, plus %0d unused op items; %0d responses checked, %0d mismatches",
                 queries_sent, unused_sent, lookups_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/nscl_pkg.sv
rtl/nscl_head.sv
rtl/nscl_cell.sv
rtl/nearest_seed_color_lookup.sv
tb/nearest_seed_color_lookup_tb.sv
